/* sv/mzit_pkg.sv */
// Shared types, codes and constants of the multi-zone irrigation timer.
package mzit_pkg;

  // Parameter defaults
  localparam int ZonesDefault         = 4;
  localparam int MaxRunMinutesDefault = 120;

  // Field widths
  localparam int ReqW     = 3;
  localparam int ZoneW    = 2;
  localparam int TimeW    = 32;
  localparam int DomW     = 5;
  localparam int DowW     = 3;
  localparam int HourW    = 5;
  localparam int MinuteW  = 6;
  localparam int RunMinW  = 16;
  localparam int MaskW    = 4;
  localparam int InDataW  = 72;
  localparam int OutDataW = 16;

  // Configuration port
  localparam int CntW     = 3;
  localparam int DayMaskW = 28;
  localparam int CfgIdxW  = 1;
  localparam logic [CfgIdxW-1:0] CfgZoneCount = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDayMasks  = 1'b1;

  // Request codes on the input channel
  localparam logic [ReqW-1:0] ReqTick    = 3'd0;
  localparam logic [ReqW-1:0] ReqStart   = 3'd1;
  localparam logic [ReqW-1:0] ReqStop    = 3'd2;
  localparam logic [ReqW-1:0] ReqSched   = 3'd3;
  localparam logic [ReqW-1:0] ReqEnable  = 3'd4;
  localparam logic [ReqW-1:0] ReqDisable = 3'd5;

  // Calendar and timing constants
  localparam int DaysPerWeek = 7;
  localparam int DayZones    = DayMaskW / DaysPerWeek;
  localparam logic [HourW-1:0]   MaxHour   = 5'd23;
  localparam logic [MinuteW-1:0] MaxMinute = 6'd59;
  localparam logic [TimeW-1:0]   MsPerMin  = 32'd60000;
  localparam logic [DomW:0]      NoDaySeen = 6'd63;

  // Zone table reset values
  localparam logic [TimeW-1:0]   ResetLimitMs = 32'(15 * 60000);
  localparam logic [HourW-1:0]   ResetHour    = 5'd8;
  localparam logic [MinuteW-1:0] ResetMinute  = 6'd0;

  // Request queue
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    OP_TICK,
    OP_START,
    OP_STOP,
    OP_SCHED,
    OP_ENABLE,
    OP_DISABLE,
    OP_NONE
  } op_t;

  // One classified request on its way to the executor
  typedef struct packed {
    op_t                op;
    logic [ZoneW-1:0]   zone;
    logic [TimeW-1:0]   now_ms;
    logic [DomW-1:0]    dom;
    logic [DowW-1:0]    dow;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic               arg_ok;
    logic [TimeW-1:0]   dur_ms;
  } item_t;

endpackage

/* sv/mzit_front.sv */
// Request classifier: decodes the request, checks its arguments, scales the duration.
module mzit_front
  import mzit_pkg::*;
#(
  parameter int MAX_RUN_MINUTES = MaxRunMinutesDefault
) (
  input  logic [ReqW-1:0]    req_type,
  input  logic [ZoneW-1:0]   zone,
  input  logic [TimeW-1:0]   now_ms,
  input  logic [DomW-1:0]    day_of_month,
  input  logic [DowW-1:0]    day_of_week,
  input  logic [HourW-1:0]   hour,
  input  logic [MinuteW-1:0] minute,
  input  logic [RunMinW-1:0] run_minutes,
  output item_t              item
);

  localparam logic [RunMinW-1:0] MaxRun = RunMinW'(MAX_RUN_MINUTES);

  op_t                op;
  logic [RunMinW-1:0] clamp_min;
  logic               arg_ok;

  always_comb begin
    unique case (req_type)
      ReqTick:    op = OP_TICK;
      ReqStart:   op = OP_START;
      ReqStop:    op = OP_STOP;
      ReqSched:   op = OP_SCHED;
      ReqEnable:  op = OP_ENABLE;
      ReqDisable: op = OP_DISABLE;
      default:    op = OP_NONE;
    endcase
  end

  assign clamp_min = (run_minutes > MaxRun) ? MaxRun : run_minutes;

  // Start clamps, schedule rejects out-of-range values
  always_comb begin
    unique case (op)
      OP_START: arg_ok = (clamp_min != '0);
      OP_SCHED: arg_ok = (hour <= MaxHour) && (minute <= MaxMinute) &&
                         (run_minutes != '0) && (run_minutes <= MaxRun);
      default:  arg_ok = 1'b0;
    endcase
  end

  always_comb begin
    item.op     = op;
    item.zone   = zone;
    item.now_ms = now_ms;
    item.dom    = day_of_month;
    item.dow    = day_of_week;
    item.hour   = hour;
    item.minute = minute;
    item.arg_ok = arg_ok;
    item.dur_ms = TimeW'(clamp_min) * MsPerMin;
  end

endmodule

/* sv/mzit_queue.sv */
// Short request queue between the classifier and the executor.
module mzit_queue
  import mzit_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  item_t             entry_r [QDepth];
  logic [QPtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0]  count_r, count_nxt;
  logic              push, pop;

  assign push_ready = (count_r != QCntW'(QDepth));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* sv/mzit_back.sv */
// Executor: zone table, configuration registers and the result register.
module mzit_back
  import mzit_pkg::*;
#(
  parameter int ZONES = ZonesDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  item_t               itm,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [DayMaskW-1:0] cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OutDataW-1:0] out_data,
  output logic                out_ok
);

  // Zone table
  logic               running_r [ZONES];
  logic               running_nxt [ZONES];
  logic [TimeW-1:0]   start_r [ZONES];
  logic [TimeW-1:0]   start_nxt [ZONES];
  logic [TimeW-1:0]   limit_r [ZONES];
  logic [TimeW-1:0]   limit_nxt [ZONES];
  logic [HourW-1:0]   hour_r [ZONES];
  logic [HourW-1:0]   hour_nxt [ZONES];
  logic [MinuteW-1:0] minute_r [ZONES];
  logic [MinuteW-1:0] minute_nxt [ZONES];
  logic               enabled_r [ZONES];
  logic               enabled_nxt [ZONES];
  logic               ran_r [ZONES];
  logic               ran_nxt [ZONES];
  logic               started [ZONES];
  logic               stopped [ZONES];
  logic               hit_run [ZONES];

  logic [CntW-1:0]     active_zones_r, active_zones_nxt;
  logic [DayMaskW-1:0] day_masks_r, day_masks_nxt;
  logic [DomW:0]       last_day_r, last_day_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [OutDataW-1:0] out_data_r, out_data_nxt;
  logic                out_ok_r, out_ok_nxt;

  logic              pop;
  logic              zone_ok;
  logic              day_chg;
  logic [DowW-1:0]   day_idx;
  logic              sel_running;
  logic              ok;
  logic [MaskW-1:0]  run_mask, start_mask, stop_mask;

  assign q_ready   = !out_valid_r || out_ready;
  assign pop       = q_valid && q_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_ok    = out_ok_r;

  assign zone_ok = (32'(itm.zone) < ZONES) && (active_zones_r > {1'b0, itm.zone});
  assign day_chg = ({1'b0, itm.dom} != last_day_r);
  // Saturday is bit 0, Sunday bit 1, ... Friday bit 6; weekday 7 maps like Sunday
  assign day_idx = (itm.dow >= 3'd6) ? itm.dow - 3'd6 : itm.dow + 3'd1;

  for (genvar i = 0; i < ZONES; i++) begin : g_zone
    logic             in_use, hit, expired, ran_clr, tstop, run_after, allowed, tstart;
    logic [TimeW-1:0] elapsed;

    assign in_use    = (32'(active_zones_r) > i);
    assign hit       = zone_ok && (32'(itm.zone) == i);
    assign elapsed   = itm.now_ms - start_r[i];
    assign expired   = running_r[i] && (elapsed >= limit_r[i]);
    assign ran_clr   = day_chg ? 1'b0 : ran_r[i];
    assign tstop     = in_use && expired;
    assign run_after = running_r[i] && !tstop;
    assign hit_run[i] = hit && running_r[i];

    if (i < DayZones) begin : g_days
      logic [DaysPerWeek-1:0] zdays;
      assign zdays   = day_masks_r[i*DaysPerWeek +: DaysPerWeek];
      assign allowed = zdays[day_idx];
    end else begin : g_nodays
      assign allowed = 1'b0;
    end

    assign tstart = in_use && !run_after && enabled_r[i] && !ran_clr && allowed &&
                    (itm.hour == hour_r[i]) && (itm.minute == minute_r[i]);

    always_comb begin
      running_nxt[i] = running_r[i];
      start_nxt[i]   = start_r[i];
      limit_nxt[i]   = limit_r[i];
      hour_nxt[i]    = hour_r[i];
      minute_nxt[i]  = minute_r[i];
      enabled_nxt[i] = enabled_r[i];
      ran_nxt[i]     = ran_r[i];
      started[i]     = 1'b0;
      stopped[i]     = 1'b0;
      if (pop) begin
        unique case (itm.op)
          OP_TICK: begin
            if (in_use) begin
              ran_nxt[i] = ran_clr;
              if (tstop) begin
                running_nxt[i] = 1'b0;
                start_nxt[i]   = '0;
                stopped[i]     = 1'b1;
              end
              // A zone stopped above may start again in the same tick
              if (tstart) begin
                ran_nxt[i]     = 1'b1;
                running_nxt[i] = 1'b1;
                start_nxt[i]   = itm.now_ms;
                started[i]     = 1'b1;
              end
            end
          end
          OP_START: begin
            if (hit && itm.arg_ok) begin
              running_nxt[i] = 1'b1;
              start_nxt[i]   = itm.now_ms;
              limit_nxt[i]   = itm.dur_ms;
              started[i]     = 1'b1;
            end
          end
          OP_STOP: begin
            if (hit && running_r[i]) begin
              running_nxt[i] = 1'b0;
              start_nxt[i]   = '0;
              stopped[i]     = 1'b1;
            end
          end
          OP_SCHED: begin
            if (hit && itm.arg_ok) begin
              hour_nxt[i]   = itm.hour;
              minute_nxt[i] = itm.minute;
              limit_nxt[i]  = itm.dur_ms;
            end
          end
          OP_ENABLE: begin
            if (hit) begin
              enabled_nxt[i] = 1'b1;
            end
          end
          OP_DISABLE: begin
            if (hit) begin
              enabled_nxt[i] = 1'b0;
              if (running_r[i]) begin
                running_nxt[i] = 1'b0;
                start_nxt[i]   = '0;
                stopped[i]     = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        running_r[i] <= 1'b0;
        start_r[i]   <= '0;
        limit_r[i]   <= ResetLimitMs;
        hour_r[i]    <= ResetHour;
        minute_r[i]  <= ResetMinute;
        enabled_r[i] <= 1'b0;
        ran_r[i]     <= 1'b0;
      end else begin
        running_r[i] <= running_nxt[i];
        start_r[i]   <= start_nxt[i];
        limit_r[i]   <= limit_nxt[i];
        hour_r[i]    <= hour_nxt[i];
        minute_r[i]  <= minute_nxt[i];
        enabled_r[i] <= enabled_nxt[i];
        ran_r[i]     <= ran_nxt[i];
      end
    end
  end

  // Only the first four zones are visible in the masks and drive the pump
  for (genvar k = 0; k < MaskW; k++) begin : g_mask
    if (k < ZONES) begin : g_live
      assign run_mask[k]   = running_nxt[k];
      assign start_mask[k] = started[k];
      assign stop_mask[k]  = stopped[k];
    end else begin : g_dead
      assign run_mask[k]   = 1'b0;
      assign start_mask[k] = 1'b0;
      assign stop_mask[k]  = 1'b0;
    end
  end

  always_comb begin
    sel_running = 1'b0;
    for (int i = 0; i < ZONES; i++) begin
      sel_running = sel_running | hit_run[i];
    end
  end

  always_comb begin
    unique case (itm.op) inside
      OP_TICK:                ok = 1'b1;
      OP_START, OP_SCHED:     ok = zone_ok && itm.arg_ok;
      OP_STOP:                ok = zone_ok && sel_running;
      OP_ENABLE, OP_DISABLE:  ok = zone_ok;
      default:                ok = 1'b0;
    endcase
  end

  // Configuration and shared calendar state
  always_comb begin
    active_zones_nxt = active_zones_r;
    day_masks_nxt    = day_masks_r;
    last_day_nxt     = last_day_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CfgZoneCount: active_zones_nxt = cfg_data[CntW-1:0];
        CfgDayMasks:  day_masks_nxt    = cfg_data;
        default: begin
        end
      endcase
    end else if (pop) begin
      if (itm.op == OP_TICK && day_chg) begin
        last_day_nxt = {1'b0, itm.dom};
      end
      if (itm.op == OP_SCHED && zone_ok && itm.arg_ok) begin
        for (int k = 0; k < DayZones; k++) begin
          if (itm.zone == ZoneW'(k)) begin
            day_masks_nxt[k*DaysPerWeek +: DaysPerWeek] = '1;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_ok_nxt    = out_ok_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {3'b000, stop_mask, start_mask, |run_mask, run_mask};
      out_ok_nxt    = ok;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_zones_r <= '0;
      day_masks_r    <= '1;
      last_day_r     <= NoDaySeen;
      out_valid_r    <= 1'b0;
    end else begin
      active_zones_r <= active_zones_nxt;
      day_masks_r    <= day_masks_nxt;
      last_day_r     <= last_day_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_ok_r   <= out_ok_nxt;
  end

endmodule

/* sv/multi_zone_irrigation_timer.sv */
// Top level of the multi-zone irrigation timer: stream ports, classifier, queue, executor.
//
// A request accepted into the request queue is popped by the executor, which registers its result on out_tvalid.
// Throughput: one request per cycle while results are taken; the executor updates all zones in parallel.
// in_tready drops only when the two-entry request queue is full, which happens
// when out_tready is held low; cfg_ready is always high.
// Reset (rst_n low, synchronous) loads the zone table defaults; no clearing pass.
module multi_zone_irrigation_timer
  import mzit_pkg::*;
#(
  parameter int ZONES           = ZonesDefault,
  parameter int MAX_RUN_MINUTES = MaxRunMinutesDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  // Request channel
  input  logic                in_tvalid,
  output logic                in_tready,
  // zone[1:0], now_ms[33:2], day_of_month[38:34], day_of_week[41:39],
  // hour[46:42], minute[52:47], run_minutes[68:53], zero fill [71:69]
  input  logic [InDataW-1:0]  in_tdata,
  // req_type[2:0]
  input  logic [ReqW-1:0]     in_tuser,
  // Result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  // running_mask[3:0], pump_on[4], started_mask[8:5], stopped_mask[12:9], zero fill [15:13]
  output logic [OutDataW-1:0] out_tdata,
  // ok[0]
  output logic                out_tuser,
  // Configuration write channel: index 0 active zone count, index 1 day_masks
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [DayMaskW-1:0] cfg_data
);

  item_t front_item;
  item_t q_item;
  logic  q_valid;
  logic  q_ready;

  // Register writes are always accepted; never hold them off
  assign cfg_ready = 1'b1;

  // Classify the request and scale its duration to milliseconds
  mzit_front #(
    .MAX_RUN_MINUTES (MAX_RUN_MINUTES)
  ) u_front (
    .req_type     (in_tuser),
    .zone         (in_tdata[1:0]),
    .now_ms       (in_tdata[33:2]),
    .day_of_month (in_tdata[38:34]),
    .day_of_week  (in_tdata[41:39]),
    .hour         (in_tdata[46:42]),
    .minute       (in_tdata[52:47]),
    .run_minutes  (in_tdata[68:53]),
    .item         (front_item)
  );

  // Hold classified requests while the result side stalls
  mzit_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // Advance the zone table and register the result
  mzit_back #(
    .ZONES (ZONES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .itm       (q_item),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_ok    (out_tuser)
  );

endmodule

/* sim/multi_zone_irrigation_timer_tb.sv */
// Self-checking testbench for the multi-zone irrigation timer: zone table predictor and stream drivers.
module multi_zone_irrigation_timer_tb;
  import mzit_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod     = 10;
  localparam int ResetCycles   = 6;
  localparam int CycleLimit    = 400000;
  localparam int SettleCycles  = 8;
  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 225;
  localparam int MaxIdle       = 15;
  localparam int MaxReports    = 40;
  localparam int MinPerHour    = 60;
  localparam int MinPerDay     = 1440;
  localparam int DaysPerMonth  = 31;
  localparam int ResetRunMin   = ResetLimitMs / MsPerMin;

  // Request codes the block leaves unused; both must be refused
  localparam logic [ReqW-1:0] ReqSpareLo = 3'd6;
  localparam logic [ReqW-1:0] ReqSpareHi = 3'd7;
  // Weekday code past Saturday; the block folds it onto Sunday
  localparam logic [DowW-1:0] SundayAlias = 3'd7;

  // One result as the block reports it
  typedef struct packed {
    logic             ok;
    logic [MaskW-1:0] running;
    logic             pump;
    logic [MaskW-1:0] started;
    logic [MaskW-1:0] stopped;
  } zone_report_t;

  // Zone table predictor plus the queue of reports still owed by the block
  class zone_table_checker;
    logic [CntW-1:0]     active_zones;
    logic [DayMaskW-1:0] day_masks;
    logic                run_flag    [ZonesDefault];
    logic [TimeW-1:0]    start_stamp [ZonesDefault];
    logic [RunMinW-1:0]  run_len     [ZonesDefault];
    logic [HourW-1:0]    sched_hour  [ZonesDefault];
    logic [MinuteW-1:0]  sched_min   [ZonesDefault];
    logic                armed       [ZonesDefault];
    logic                done_today  [ZonesDefault];
    logic [DomW:0]       last_dom;
    logic [MaskW-1:0]    started;
    logic [MaskW-1:0]    stopped;
    zone_report_t        reports_due[$];
    int accepted, checked, errors, rejected, sched_starts, timed_stops, settings;

    function new();
      active_zones = '0;
      day_masks    = '1;
      foreach (run_flag[i]) begin
        run_flag[i]    = 1'b0;
        start_stamp[i] = '0;
        run_len[i]     = RunMinW'(ResetRunMin);
        sched_hour[i]  = ResetHour;
        sched_min[i]   = ResetMinute;
        armed[i]       = 1'b0;
        done_today[i]  = 1'b0;
      end
      last_dom = NoDaySeen;
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [DayMaskW-1:0] data);
      settings++;
      if (idx == CfgZoneCount) active_zones = data[CntW-1:0];
      else day_masks = data;
    endfunction

    function int in_use();
      return (active_zones < ZonesDefault) ? int'(active_zones) : ZonesDefault;
    endfunction

    // Weekday d runs Saturday=1 .. Friday=7; code 7 folds onto Sunday
    function bit day_ok(int i, logic [DowW-1:0] dow);
      int d, b;
      d = (int'(dow) + 2 > DaysPerWeek) ? int'(dow) - 5 : int'(dow) + 2;
      b = i * DaysPerWeek + d - 1;
      if (b >= DayMaskW) return 1'b0;
      return day_masks[b];
    endfunction

    function bit try_start(int i, int unsigned minutes, logic [TimeW-1:0] now);
      if (i >= in_use()) return 1'b0;
      if (minutes > MaxRunMinutesDefault) minutes = MaxRunMinutesDefault;
      if (minutes == 0) return 1'b0;
      run_flag[i]    = 1'b1;
      run_len[i]     = RunMinW'(minutes);
      start_stamp[i] = now;
      started[i]     = 1'b1;
      return 1'b1;
    endfunction

    function bit try_stop(int i);
      if (i >= in_use() || !run_flag[i]) return 1'b0;
      run_flag[i]    = 1'b0;
      start_stamp[i] = '0;
      stopped[i]     = 1'b1;
      return 1'b1;
    endfunction

    function void tick(logic [TimeW-1:0] now, logic [DomW-1:0] dom, logic [DowW-1:0] dow,
                       logic [HourW-1:0] hour, logic [MinuteW-1:0] minute);
      int n, i;
      logic [TimeW-1:0] elapsed;
      n = in_use();
      if ({1'b0, dom} != last_dom) begin
        last_dom = {1'b0, dom};
        for (i = 0; i < n; i++) done_today[i] = 1'b0;
      end
      for (i = 0; i < n; i++) begin
        if (run_flag[i]) begin
          elapsed = now - start_stamp[i];
          if (elapsed >= TimeW'(run_len[i]) * MsPerMin) begin
            void'(try_stop(i));
            timed_stops++;
          end
        end
      end
      for (i = 0; i < n; i++) begin
        if (run_flag[i] || !armed[i] || done_today[i]) continue;
        if (!day_ok(i, dow)) continue;
        if (hour != sched_hour[i] || minute != sched_min[i]) continue;
        done_today[i] = 1'b1;
        if (try_start(i, run_len[i], now)) sched_starts++;
      end
    endfunction

    function void note_request(logic [ReqW-1:0] req, logic [ZoneW-1:0] zone,
                               logic [TimeW-1:0] now, logic [DomW-1:0] dom,
                               logic [DowW-1:0] dow, logic [HourW-1:0] hour,
                               logic [MinuteW-1:0] minute, logic [RunMinW-1:0] run_min);
      zone_report_t     exp;
      logic [MaskW-1:0] running;
      logic             ok;
      int               n, i;
      started = '0;
      stopped = '0;
      ok      = 1'b0;
      n       = in_use();
      case (req)
        ReqTick: begin
          tick(now, dom, dow, hour, minute);
          ok = 1'b1;
        end
        ReqStart: ok = try_start(zone, run_min, now);
        ReqStop:  ok = try_stop(zone);
        ReqSched: begin
          if (zone < n && hour <= MaxHour && minute <= MaxMinute && run_min != 0 &&
              run_min <= MaxRunMinutesDefault) begin
            sched_hour[zone] = hour;
            sched_min[zone]  = minute;
            run_len[zone]    = run_min;
            day_masks |= DayMaskW'({DaysPerWeek{1'b1}}) << (int'(zone) * DaysPerWeek);
            ok = 1'b1;
          end
        end
        ReqEnable: begin
          if (zone < n) begin
            armed[zone] = 1'b1;
            ok = 1'b1;
          end
        end
        ReqDisable: begin
          if (zone < n) begin
            armed[zone] = 1'b0;
            void'(try_stop(zone));
            ok = 1'b1;
          end
        end
        default: ok = 1'b0;
      endcase
      for (i = 0; i < ZonesDefault; i++) running[i] = run_flag[i];
      exp = '{ok, running, |running, started, stopped};
      reports_due.push_back(exp);
      accepted++;
      if (!ok) rejected++;
    endfunction

    function void compare(string name, int unsigned e, int unsigned a);
      if (e == a) return;
      errors++;
      if (errors <= MaxReports)
        $display("%0t: result %0d, %s expected %0h actual %0h", $time, checked, name, e, a);
    endfunction

    function void check_result(logic ok_bit, logic [OutDataW-1:0] data);
      zone_report_t exp, got;
      got = '{ok_bit, data[3:0], data[4], data[8:5], data[12:9]};
      if (reports_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %0h", $time, got);
        return;
      end
      exp = reports_due.pop_front();
      checked++;
      compare("ok", exp.ok, got.ok);
      compare("running_mask", exp.running, got.running);
      compare("pump_on", exp.pump, got.pump);
      compare("started_mask", exp.started, got.started);
      compare("stopped_mask", exp.stopped, got.stopped);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic [ReqW-1:0]     in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [DayMaskW-1:0] cfg_data = '0;

  zone_table_checker board;

  // Per-phase idling switches: off gives back-to-back traffic on that side
  bit in_idle_on   = 1'b1;
  bit out_stall_on = 1'b1;

  // Wall clock the random ticks walk through
  logic [TimeW-1:0] cal_ms;
  int               cal_min, cal_dom, cal_dow;

  int cycle_count = 0;

  multi_zone_irrigation_timer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Watchdog: end the run if the traffic stops moving
  initial begin
    while (cycle_count < CycleLimit) @(posedge clk) cycle_count++;
    $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_count,
             board.reports_due.size());
    $display("== FAIL ==");
    $finish;
  end

  // Drive one request; enter and leave on a falling edge, predict on acceptance
  task automatic send_request(logic [ReqW-1:0] req, logic [ZoneW-1:0] zone,
                              logic [TimeW-1:0] now, logic [DomW-1:0] dom,
                              logic [DowW-1:0] dow, logic [HourW-1:0] hour,
                              logic [MinuteW-1:0] minute, logic [RunMinW-1:0] run_min);
    int gap;
    gap = in_idle_on ? $urandom_range(0, MaxIdle) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {3'b000, run_min, minute, hour, dow, dom, now, zone};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    board.note_request(req, zone, now, dom, dow, hour, minute, run_min);
    @(negedge clk);
  endtask

  // Accept results forever, stalling a random number of cycles before each one while out_stall_on is set
  task automatic drain_results();
    int hold;
    forever begin
      hold = out_stall_on ? $urandom_range(0, MaxIdle) : 0;
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      board.check_result(out_tuser, out_tdata);
      @(negedge clk);
    end
  endtask

  // Hold valid until the write is taken, then drop it on a falling edge before returning
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DayMaskW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    board.write_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Drop the request valid, wait for every owed result, then let the pipe drain
  task automatic settle();
    in_tvalid <= 1'b0;
    while (board.reports_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Corners first: clamping, refusals, wrap of the ms counter, same-tick restart
  task automatic run_directed();
    // First tick: seed the day and leave every zone idle
    send_request(ReqTick, 2'd0, 32'd0, 5'd1, 3'd0, 5'd0, 6'd0, 16'd0);
    // Zero duration is refused; an oversize one clamps; a second start restarts
    send_request(ReqStart, 2'd0, 32'd1000, 5'd1, 3'd0, 5'd0, 6'd0, 16'd0);
    send_request(ReqStart, 2'd0, 32'd1000, 5'd1, 3'd0, 5'd0, 6'd0, 16'hFFFF);
    send_request(ReqStart, 2'd0, 32'd2000, 5'd1, 3'd0, 5'd0, 6'd0, 16'd5);
    // Zone 1 starts right before the ms counter wraps
    send_request(ReqStart, 2'd1, 32'hFFFF_FFFF, 5'd1, 3'd0, 5'd0, 6'd0, 16'd1);
    // Stop of an idle zone is refused; stop of a running one succeeds
    send_request(ReqStop, 2'd2, 32'd0, 5'd1, 3'd0, 5'd0, 6'd0, 16'd0);
    send_request(ReqStop, 2'd0, 32'd0, 5'd1, 3'd0, 5'd0, 6'd0, 16'd0);
    // Schedule refusals: hour, minute, zero and oversize duration
    send_request(ReqSched, 2'd2, 32'd0, 5'd1, 3'd0, 5'd24, 6'd0, 16'd10);
    send_request(ReqSched, 2'd2, 32'd0, 5'd1, 3'd0, 5'd23, 6'd60, 16'd10);
    send_request(ReqSched, 2'd2, 32'd0, 5'd1, 3'd0, 5'd23, 6'd59, 16'd0);
    send_request(ReqSched, 2'd2, 32'd0, 5'd1, 3'd0, 5'd23, 6'd59, 16'd121);
    send_request(ReqSched, 2'd2, 32'd0, 5'd1, 3'd0, 5'd23, 6'd59, 16'd120);
    send_request(ReqSched, 2'd3, 32'd0, 5'd1, 3'd0, 5'd0, 6'd0, 16'd1);
    send_request(ReqEnable, 2'd3, 32'd0, 5'd1, 3'd0, 5'd0, 6'd0, 16'd0);
    send_request(ReqEnable, 2'd2, 32'd0, 5'd1, 3'd0, 5'd0, 6'd0, 16'd0);
    // New day on the folded Sunday code: zone 1 times out across the wrap, zone 3 starts
    send_request(ReqTick, 2'd0, 32'd59999, 5'd2, SundayAlias, 5'd0, 6'd0, 16'd0);
    // Next day: zone 3 times out and restarts within the same tick
    send_request(ReqTick, 2'd0, 32'd119999, 5'd3, 3'd1, 5'd0, 6'd0, 16'd0);
    // Saturday at out-of-range clock time
    send_request(ReqTick, 2'd0, 32'd200000, 5'd3, 3'd6, 5'd31, 6'd63, 16'd0);
    // Disable of an idle zone, then of a running one
    send_request(ReqDisable, 2'd2, 32'd0, 5'd3, 3'd0, 5'd0, 6'd0, 16'd0);
    send_request(ReqStart, 2'd2, 32'd210000, 5'd3, 3'd0, 5'd0, 6'd0, 16'd120);
    send_request(ReqDisable, 2'd2, 32'd0, 5'd3, 3'd0, 5'd0, 6'd0, 16'd0);
    // Unused request codes, one with every field bit set
    send_request(ReqSpareLo, 2'd3, 32'd0, 5'd1, 3'd0, 5'd0, 6'd0, 16'd0);
    send_request(ReqSpareHi, 2'd3, 32'hFFFF_FFFF, 5'd31, SundayAlias, 5'd31, 6'd63, 16'hFFFF);
    send_request(ReqEnable, 2'd0, 32'd0, 5'd1, 3'd0, 5'd0, 6'd0, 16'd0);
  endtask

  // Mostly well-formed traffic against a walking wall clock, some pure noise
  task automatic random_request();
    int               kind, delta, target;
    logic [ZoneW-1:0] z;
    logic [DowW-1:0]  dow;
    z    = ZoneW'($urandom_range(0, ZonesDefault - 1));
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      // Advance by up to two minutes; now and then skip hours to roll the day
      delta = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 3000) : $urandom_range(0, 2);
      cal_ms  += TimeW'(delta) * MsPerMin + TimeW'($urandom_range(0, 999));
      cal_min += delta;
      while (cal_min >= MinPerDay) begin
        cal_min -= MinPerDay;
        cal_dom = (cal_dom == DaysPerMonth) ? 1 : cal_dom + 1;
        cal_dow = (cal_dow + 1) % DaysPerWeek;
      end
      dow = (cal_dow == 0 && $urandom_range(0, 1) == 1) ? SundayAlias : DowW'(cal_dow);
      send_request(ReqTick, z, cal_ms, DomW'(cal_dom), dow, HourW'(cal_min / MinPerHour),
                   MinuteW'(cal_min % MinPerHour), RunMinW'($urandom));
    end else if (kind < 52) begin
      case ($urandom_range(0, 9))
        0:       target = 0;
        1:       target = $urandom_range(MaxRunMinutesDefault + 1, 65535);
        default: target = $urandom_range(1, 6);
      endcase
      send_request(ReqStart, z, cal_ms, DomW'($urandom_range(1, DaysPerMonth)), DowW'($urandom),
                   HourW'($urandom), MinuteW'($urandom), RunMinW'(target));
    end else if (kind < 60) begin
      send_request(ReqStop, z, $urandom, DomW'($urandom_range(1, DaysPerMonth)), DowW'($urandom),
                   HourW'($urandom), MinuteW'($urandom), RunMinW'($urandom));
    end else if (kind < 72) begin
      if ($urandom_range(0, 5) != 0) begin
        // Aim a few minutes ahead so upcoming ticks hit it
        target = (cal_min + $urandom_range(0, 4)) % MinPerDay;
        send_request(ReqSched, z, $urandom, DomW'(cal_dom), DowW'(cal_dow),
                     HourW'(target / MinPerHour), MinuteW'(target % MinPerHour),
                     RunMinW'($urandom_range(1, 4)));
      end else begin
        send_request(ReqSched, z, $urandom, DomW'(cal_dom), DowW'(cal_dow), HourW'($urandom),
                     MinuteW'($urandom), RunMinW'($urandom_range(0, 200)));
      end
    end else if (kind < 84) begin
      send_request(ReqEnable, z, $urandom, DomW'($urandom_range(1, DaysPerMonth)),
                   DowW'($urandom), HourW'($urandom), MinuteW'($urandom), RunMinW'($urandom));
    end else if (kind < 90) begin
      send_request(ReqDisable, z, $urandom, DomW'($urandom_range(1, DaysPerMonth)),
                   DowW'($urandom), HourW'($urandom), MinuteW'($urandom), RunMinW'($urandom));
    end else begin
      send_request(ReqW'($urandom), z, $urandom, DomW'($urandom_range(1, DaysPerMonth)),
                   DowW'($urandom), HourW'($urandom), MinuteW'($urandom), RunMinW'($urandom));
    end
  endtask

  initial begin
    // Zone count per phase: the drop to one leaves higher zones running
    int unsigned phase_count [NumPhases] = '{4, 4, 1, 0, 2, 3, 4, 4};
    // Day mask per phase: 0 all days, 1 no days, 2 random
    int          phase_masks [NumPhases] = '{0, 2, 2, 2, 1, 2, 2, 0};
    logic [DayMaskW-1:0] masks;
    int p;

    board   = new();
    cal_ms  = 32'hFFF0_0000;
    cal_min = 7 * MinPerHour + 50;
    cal_dom = 1;
    cal_dow = 0;

    // Hold reset, then release on a falling edge
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    fork
      drain_results();
    join_none
    @(negedge clk);

    write_reg(CfgZoneCount, DayMaskW'(ZonesDefault));
    write_reg(CfgDayMasks, '1);
    run_directed();

    for (p = 0; p < NumPhases; p++) begin
      settle();
      case (phase_masks[p])
        0:       masks = '1;
        1:       masks = '0;
        default: masks = DayMaskW'($urandom);
      endcase
      write_reg(CfgZoneCount, DayMaskW'(phase_count[p]));
      write_reg(CfgDayMasks, masks);
      // Mix idle and back-to-back stretches on both sides
      in_idle_on   = (p % 3 != 1);
      out_stall_on = (p % 4 != 3);
      repeat (ItemsPerPhase) random_request();
    end
    settle();

    $display("Ran %0d requests (%0d refused) over %0d register writes, %0d results checked.",
             board.accepted, board.rejected, board.settings, board.checked);
    $display("Saw %0d scheduled starts and %0d timed stops; %0d mismatches.",
             board.sched_starts, board.timed_stops, board.errors);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/mzit_pkg.sv
sv/mzit_front.sv
sv/mzit_queue.sv
sv/mzit_back.sv
sv/multi_zone_irrigation_timer.sv
sim/multi_zone_irrigation_timer_tb.sv
